[rtl/core/trc_pkg.sv]
// Shared types and constants for the threshold reachability counter.
// Depends on nothing; imported by the top level and the engine.
package trc_pkg;

	// Fixed field widths
	localparam int VTX_W   = 10;
	localparam int EIDX_W  = 11;
	localparam int WT_W    = 32;
	localparam int CNT_O_W = 11;
	localparam int VC_W    = 11;
	localparam int EC_W    = 12;
	localparam int CFG_W   = 12;
	localparam int CIDX_W  = 1;

	// Configuration register indices and reset values
	localparam logic [CIDX_W-1:0] REG_VERTEX_COUNT = 1'b0;
	localparam logic [CIDX_W-1:0] REG_EDGE_COUNT   = 1'b1;
	localparam logic [VC_W-1:0]   VC_RESET = 11'd1024;
	localparam logic [EC_W-1:0]   EC_RESET = 12'd0;

	typedef enum logic [1:0] {
		ACT_LOAD   = 2'd0,
		ACT_UPDATE = 2'd1,
		ACT_QUERY  = 2'd2
	} action_t;

	typedef enum logic [2:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_FETCH,
		ST_HERE,
		ST_SCAN,
		ST_DONE,
		ST_CLEAN
	} state_t;

	// Query command from the front end to the search engine
	typedef struct packed {
		logic             go;
		logic [VTX_W-1:0] start;
		logic [WT_W-1:0]  threshold;
	} query_cmd_t;

	// One edge table entry as read back
	typedef struct packed {
		logic [VTX_W-1:0] end_a;
		logic [VTX_W-1:0] end_b;
		logic [WT_W-1:0]  weight;
	} edge_rec_t;

	// Engine status back to the front end
	typedef struct packed {
		logic               busy;
		logic               done;
		logic [CNT_O_W-1:0] count;
	} engine_stat_t;

endpackage

[rtl/core/threshold_reachability_counter.sv]
// Top level of the threshold reachability counter: command port, config
// registers and edge table RAMs. Uses trc_pkg, trc_ram and trc_engine.
//
// Usage
//   Command channel: a word is taken at a rising edge with start high and
//   busy low. action selects load (end_a, end_b, weight into edge_index),
//   weight update of edge_index, or a query from start_vertex with weight as
//   the threshold. Loads and updates go straight to the RAMs; busy stays low.
//   Result channel: each query gives one reachable_count, marked by a one
//   cycle done strobe. The receiver cannot stall; the word is simply there.
//   A query from a start at or beyond vertex_count strobes 0 the next cycle.
//   Otherwise the result comes when the search ends: the live edge table is
//   streamed through its single read port once per dequeued vertex.
//   Busy stays high through the strobe cycle and after it while the visited
//   marks of the reached vertices are cleared from the queue.
//   Config port: cfg_we writes cfg_data into register cfg_index (vertex
//   count, edge count) at once; write only while idle.
//   Reset: registers take their reset values, then a clearing pass over all
//   MAX_VERTICES entries wipes the visited marks with busy high.
module threshold_reachability_counter
	import trc_pkg::*;
#(
	parameter int MAX_VERTICES = 1024,
	parameter int MAX_EDGES    = 2048
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	output logic               busy,
	input  logic [1:0]         action,
	input  logic [EIDX_W-1:0]  edge_index,
	input  logic [VTX_W-1:0]   end_a,
	input  logic [VTX_W-1:0]   end_b,
	input  logic [WT_W-1:0]    weight,
	input  logic [VTX_W-1:0]   start_vertex,
	output logic               done,
	output logic [CNT_O_W-1:0] reachable_count,
	input  logic               cfg_we,
	input  logic [CIDX_W-1:0]  cfg_index,
	input  logic [CFG_W-1:0]   cfg_data
);

	localparam int CNT_W = $clog2(MAX_VERTICES + 1);
	localparam int EA_W  = (MAX_EDGES > 1) ? $clog2(MAX_EDGES) : 1;
	localparam int ECW   = $clog2(MAX_EDGES + 1);

	logic [VC_W-1:0] vertex_count_q;
	logic [EC_W-1:0] edge_count_q;

	// live sizes, saturated at the table depths
	logic [CNT_W-1:0] nv;
	logic [ECW-1:0]   ne;

	logic         accept;
	action_t      act;
	query_cmd_t   cmd;
	engine_stat_t stat;

	// edge table write side
	logic ends_we, wt_we;

	// edge table read side, driven by the engine
	logic                 edge_re;
	logic [EA_W-1:0]      edge_ra;
	logic [2*VTX_W-1:0]   ends_rd;
	logic [WT_W-1:0]      wt_rd;
	edge_rec_t            edge_rd;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vertex_count_q <= VC_RESET;
			edge_count_q   <= EC_RESET;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_VERTEX_COUNT: vertex_count_q <= cfg_data[VC_W-1:0];
				REG_EDGE_COUNT:   edge_count_q   <= cfg_data[EC_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		nv = (32'(vertex_count_q) > MAX_VERTICES) ? CNT_W'(MAX_VERTICES)
			: CNT_W'(vertex_count_q);
		ne = (32'(edge_count_q) > MAX_EDGES) ? ECW'(MAX_EDGES) : ECW'(edge_count_q);
	end

	assign accept = start && !stat.busy;
	assign act    = action_t'(action);

	// Decode the command word: loads and updates go straight to the RAMs
	always_comb begin
		ends_we       = 1'b0;
		wt_we         = 1'b0;
		cmd.go        = 1'b0;
		cmd.start     = start_vertex;
		cmd.threshold = weight;
		if (accept) begin
			unique case (act)
				ACT_LOAD: begin
					ends_we = (32'(edge_index) < MAX_EDGES);
					wt_we   = ends_we;
				end
				ACT_UPDATE: wt_we = (32'(edge_index) < 32'(ne));
				ACT_QUERY:  cmd.go = 1'b1;
				default: ;
			endcase
		end
	end

	trc_ram #(.WIDTH(2*VTX_W), .DEPTH(MAX_EDGES)) u_edge_ends (
		.clk   (clk),
		.we    (ends_we),
		.waddr (EA_W'(edge_index)),
		.wdata ({end_a, end_b}),
		.re    (edge_re),
		.raddr (edge_ra),
		.rdata (ends_rd)
	);

	trc_ram #(.WIDTH(WT_W), .DEPTH(MAX_EDGES)) u_edge_weight (
		.clk   (clk),
		.we    (wt_we),
		.waddr (EA_W'(edge_index)),
		.wdata (weight),
		.re    (edge_re),
		.raddr (edge_ra),
		.rdata (wt_rd)
	);

	assign edge_rd.end_a  = ends_rd[2*VTX_W-1:VTX_W];
	assign edge_rd.end_b  = ends_rd[VTX_W-1:0];
	assign edge_rd.weight = wt_rd;

	trc_engine #(
		.MAX_VERTICES (MAX_VERTICES),
		.MAX_EDGES    (MAX_EDGES)
	) u_engine (
		.clk     (clk),
		.arst_n  (arst_n),
		.cmd     (cmd),
		.nv      (nv),
		.ne      (ne),
		.edge_re (edge_re),
		.edge_ra (edge_ra),
		.edge_rd (edge_rd),
		.stat    (stat)
	);

	assign busy            = stat.busy;
	assign done            = stat.done;
	assign reachable_count = stat.count;

endmodule

[rtl/core/trc_ram.sv]
// Generic simple dual-port RAM: one write port, one registered read port.
// No dependencies.
module trc_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic             re,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

[rtl/core/trc_engine.sv]
// Breadth-first search engine: visited marks and frontier queue in RAM,
// edge table scanned through the front end's read port. Uses trc_pkg, trc_ram.
module trc_engine
	import trc_pkg::*;
#(
	parameter int MAX_VERTICES = 1024,
	parameter int MAX_EDGES    = 2048,
	localparam int VA_W = (MAX_VERTICES > 1) ? $clog2(MAX_VERTICES) : 1,
	localparam int CNT_W = $clog2(MAX_VERTICES + 1),
	localparam int EA_W = (MAX_EDGES > 1) ? $clog2(MAX_EDGES) : 1,
	localparam int ECW = $clog2(MAX_EDGES + 1)
) (
	input  logic             clk,
	input  logic             arst_n,
	input  query_cmd_t       cmd,
	input  logic [CNT_W-1:0] nv,
	input  logic [ECW-1:0]   ne,
	output logic             edge_re,
	output logic [EA_W-1:0]  edge_ra,
	input  edge_rec_t        edge_rd,
	output engine_stat_t     stat
);

	state_t state_q, state_d;

	logic [CNT_W-1:0]   head_q, head_d;
	logic [CNT_W-1:0]   tail_q, tail_d;
	logic [ECW-1:0]     e_q, e_d;
	logic [VTX_W-1:0]   here_q, here_d;
	logic [WT_W-1:0]    thr_q, thr_d;
	logic               v_s1, v_s1_d;
	logic               v_s2, v_s2_d;
	logic [VTX_W-1:0]   other_s2, other_s2_d;
	logic               fwd_v_q, fwd_v_d;
	logic [VTX_W-1:0]   fwd_addr_q;
	logic               clv_s1, clv_s1_d;
	logic               done_q, done_d;
	logic [CNT_O_W-1:0] count_q, count_d;

	// RAM ports
	logic             vis_we, vis_wd, vis_re, vis_rd;
	logic [VA_W-1:0]  vis_wa, vis_ra;
	logic             q_we, q_re;
	logic [VA_W-1:0]  q_wa, q_ra;
	logic [VTX_W-1:0] q_wd, q_rd;

	// Edge match (stage 1), visited check (stage 2) and issue terms
	logic             edge_ok;
	logic [VTX_W-1:0] other_s1;
	logic             seen, issue;

	trc_ram #(.WIDTH(1), .DEPTH(MAX_VERTICES)) u_visited (
		.clk   (clk),
		.we    (vis_we),
		.waddr (vis_wa),
		.wdata (vis_wd),
		.re    (vis_re),
		.raddr (vis_ra),
		.rdata (vis_rd)
	);

	trc_ram #(.WIDTH(VTX_W), .DEPTH(MAX_VERTICES)) u_queue (
		.clk   (clk),
		.we    (q_we),
		.waddr (q_wa),
		.wdata (q_wd),
		.re    (q_re),
		.raddr (q_ra),
		.rdata (q_rd)
	);

	always_comb begin
		edge_ok = (edge_rd.weight >= thr_q)
			&& (32'(edge_rd.end_a) < 32'(nv))
			&& (32'(edge_rd.end_b) < 32'(nv))
			&& ((edge_rd.end_a == here_q) || (edge_rd.end_b == here_q));
		other_s1 = (edge_rd.end_a == here_q) ? edge_rd.end_b : edge_rd.end_a;
		// write from the previous cycle is not yet visible in the read data
		seen = vis_rd || (fwd_v_q && (fwd_addr_q == other_s2));
	end

	always_comb begin
		state_d    = state_q;
		head_d     = head_q;
		tail_d     = tail_q;
		e_d        = e_q;
		here_d     = here_q;
		thr_d      = thr_q;
		v_s1_d     = 1'b0;
		v_s2_d     = 1'b0;
		other_s2_d = other_s1;
		fwd_v_d    = 1'b0;
		clv_s1_d   = 1'b0;
		done_d     = 1'b0;
		count_d    = count_q;
		vis_we     = 1'b0;
		vis_wa     = '0;
		vis_wd     = 1'b0;
		vis_re     = 1'b0;
		vis_ra     = VA_W'(other_s1);
		q_we       = 1'b0;
		q_wa       = '0;
		q_wd       = '0;
		q_re       = 1'b0;
		q_ra       = head_q[VA_W-1:0];
		edge_re    = 1'b0;
		edge_ra    = e_q[EA_W-1:0];
		issue      = 1'b0;

		unique case (state_q)
			ST_CLEAR: begin
				vis_we = 1'b1;
				vis_wa = head_q[VA_W-1:0];
				head_d = head_q + 1'b1;
				if (32'(head_q) == MAX_VERTICES - 1) begin
					head_d  = '0;
					state_d = ST_IDLE;
				end
			end
			ST_IDLE: begin
				if (cmd.go) begin
					thr_d = cmd.threshold;
					if (32'(cmd.start) >= 32'(nv)) begin
						done_d  = 1'b1;
						count_d = '0;
					end else begin
						vis_we  = 1'b1;
						vis_wa  = VA_W'(cmd.start);
						vis_wd  = 1'b1;
						q_we    = 1'b1;
						q_wa    = '0;
						q_wd    = cmd.start;
						head_d  = '0;
						tail_d  = CNT_W'(1);
						state_d = ST_FETCH;
					end
				end
			end
			ST_FETCH: begin
				if (head_q == tail_q) begin
					state_d = ST_DONE;
				end else begin
					q_re    = 1'b1;
					head_d  = head_q + 1'b1;
					state_d = ST_HERE;
				end
			end
			ST_HERE: begin
				here_d  = q_rd;
				e_d     = '0;
				state_d = ST_SCAN;
			end
			ST_SCAN: begin
				// issue: edge read; s1: match; s2: visited check and enqueue
				issue   = (e_q < ne);
				edge_re = issue;
				v_s1_d  = issue;
				if (issue) begin
					e_d = e_q + 1'b1;
				end
				vis_re = v_s1;
				v_s2_d = v_s1 && edge_ok;
				if (v_s2 && !seen && (32'(tail_q) < MAX_VERTICES)) begin
					vis_we  = 1'b1;
					vis_wa  = VA_W'(other_s2);
					vis_wd  = 1'b1;
					q_we    = 1'b1;
					q_wa    = tail_q[VA_W-1:0];
					q_wd    = other_s2;
					tail_d  = tail_q + 1'b1;
					fwd_v_d = 1'b1;
				end
				if (!issue && !v_s1 && !v_s2) begin
					state_d = ST_FETCH;
				end
			end
			ST_DONE: begin
				done_d  = 1'b1;
				count_d = CNT_O_W'(tail_q);
				head_d  = '0;
				state_d = ST_CLEAN;
			end
			ST_CLEAN: begin
				// the queue lists exactly the marked vertices: unmark them
				issue    = (head_q < tail_q);
				q_re     = issue;
				clv_s1_d = issue;
				if (issue) begin
					head_d = head_q + 1'b1;
				end
				if (clv_s1) begin
					vis_we = 1'b1;
					vis_wa = VA_W'(q_rd);
				end
				if (!issue && !clv_s1) begin
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_CLEAR;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
		end else begin
			state_q <= state_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q  <= '0;
			tail_q  <= '0;
			e_q     <= '0;
			v_s1    <= 1'b0;
			v_s2    <= 1'b0;
			fwd_v_q <= 1'b0;
			clv_s1  <= 1'b0;
			done_q  <= 1'b0;
		end else begin
			head_q  <= head_d;
			tail_q  <= tail_d;
			e_q     <= e_d;
			v_s1    <= v_s1_d;
			v_s2    <= v_s2_d;
			fwd_v_q <= fwd_v_d;
			clv_s1  <= clv_s1_d;
			done_q  <= done_d;
		end
	end

	always_ff @(posedge clk) begin
		here_q     <= here_d;
		thr_q      <= thr_d;
		other_s2   <= other_s2_d;
		fwd_addr_q <= other_s2;
		count_q    <= count_d;
	end

	assign stat.busy  = (state_q != ST_IDLE);
	assign stat.done  = done_q;
	assign stat.count = count_q;

endmodule
